// ===== hdl/lebuf_pkg.sv =====
// Shared types and constants for the line edit buffer.
`default_nettype none
package lebuf_pkg;

    // Key event codes
    localparam logic [2:0] FUNC_HOME  = 3'd0;
    localparam logic [2:0] FUNC_END   = 3'd1;
    localparam logic [2:0] FUNC_LEFT  = 3'd2;
    localparam logic [2:0] FUNC_RIGHT = 3'd3;
    localparam logic [2:0] FUNC_TYPE  = 3'd4;
    localparam logic [2:0] FUNC_ERASE = 3'd5;
    localparam logic [2:0] FUNC_READ  = 3'd6;

    // Printable character range
    localparam logic [7:0] CHAR_LOW  = 8'd32;
    localparam logic [7:0] CHAR_HIGH = 8'd126;

    // Configuration register map (register index taken from paddr[2])
    localparam int         ADDR_W         = 3;
    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;
    localparam logic [7:0] MAX_LEN_RESET  = 8'd100;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic [6:0] key;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ===== hdl/lebuf_cell.sv =====
// One character cell of the text ring.
`default_nettype none
module lebuf_cell
    import lebuf_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CW       = 8
) (
    input  wire logic            i_clk,
    input  wire t_cell_cmd       i_cmd,
    input  wire logic [CW-1:0]   i_cursor,
    input  wire logic [6:0]      i_left,
    input  wire logic [6:0]      i_right,
    output logic [6:0]           o_char
);

    localparam logic [CW:0] IDX = (CW+1)'(CELL_IDX);

    logic [CW:0] w_cur;
    logic [6:0]  n_char;
    logic [6:0]  r_char;

    assign w_cur = {1'b0, i_cursor};

    always_comb begin
        n_char = r_char;
        unique case (i_cmd.op)
            CELL_HOLD: n_char = r_char;
            CELL_INS: begin
                // open a gap at the cursor, take the key there
                if (IDX > w_cur) begin
                    n_char = i_left;
                end else if (IDX == w_cur) begin
                    n_char = i_cmd.key;
                end
            end
            CELL_DEL: begin
                // close the gap left by the character before the cursor
                if (IDX + (CW+1)'(1) >= w_cur) begin
                    n_char = i_right;
                end
            end
            CELL_ROT: n_char = i_right;
            default:  n_char = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule
`default_nettype wire

// ===== hdl/line_edit_buffer_core.sv =====
// Top level of the line edit buffer: control, registers and the cell ring.
//
// Each key event is taken on start while busy is low. Home, end, left,
// right, type, erase, an out-of-range read and an unused code give their
// result in the next cycle, and busy stays low, so an event can follow in
// every cycle. Inserts and erases shift the whole ring of cells at once.
// A read within the text turns the ring one full revolution, one cell a
// cycle, and picks the character off cell 0 on the way, with busy high
// until the result appears. The result is a one-cycle pulse on o_valid
// that the receiver cannot hold off.
`default_nettype none
module line_edit_buffer_core
    import lebuf_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // key events
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        i_func,
    input  wire logic [7:0]        i_key,
    input  wire logic [6:0]        i_index,
    // results
    output logic                   o_valid,
    output logic                   o_accepted,
    output logic [6:0]             o_read_char,
    output logic                   o_read_valid,
    output logic [7:0]             o_cursor_pos,
    output logic [7:0]             o_text_length,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = (CW > 8) ? CW : 8;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cursor, n_cursor;
    logic [CW-1:0]  r_length, n_length;
    logic [7:0]     r_max_len, n_max_len;
    logic [IW-1:0]  r_cnt, n_cnt;
    logic [6:0]     r_idx, n_idx;
    logic           r_valid, n_valid;
    logic           r_acc, n_acc;
    logic [6:0]     r_rchar, n_rchar;
    logic           r_rvalid, n_rvalid;

    t_cell_cmd      w_cmd;
    logic [6:0]     w_char [CAPACITY];
    logic [XW-1:0]  w_limit;
    logic           w_key_ok;
    logic           w_room;
    logic           w_idx_ok;
    logic           w_cfg_wr;

    // effective limit is the smaller of max_length and the capacity
    always_comb begin
        if (XW'(r_max_len) > XW'(CAPACITY)) begin
            w_limit = XW'(CAPACITY);
        end else begin
            w_limit = XW'(r_max_len);
        end
    end

    assign w_key_ok = (i_key >= CHAR_LOW) && (i_key <= CHAR_HIGH);
    assign w_room   = XW'(r_length) < w_limit;
    assign w_idx_ok = XW'(i_index) < XW'(r_length);
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2:2] == REG_MAX_LENGTH);

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_length  = r_length;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_acc     = r_acc;
        n_rchar   = r_rchar;
        n_rvalid  = r_rvalid;
        n_max_len = w_cfg_wr ? pwdata[7:0] : r_max_len;
        w_cmd.op  = CELL_HOLD;
        w_cmd.key = i_key[6:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_valid  = 1'b1;
                    n_acc    = 1'b1;
                    n_rchar  = '0;
                    n_rvalid = 1'b0;
                    unique case (i_func)
                        FUNC_HOME: n_cursor = '0;
                        FUNC_END:  n_cursor = r_length;
                        FUNC_LEFT: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - CW'(1);
                            end
                        end
                        FUNC_RIGHT: begin
                            if (r_cursor < r_length) begin
                                n_cursor = r_cursor + CW'(1);
                            end
                        end
                        FUNC_TYPE: begin
                            if (w_key_ok && w_room) begin
                                w_cmd.op = CELL_INS;
                                n_cursor = r_cursor + CW'(1);
                                n_length = r_length + CW'(1);
                            end else begin
                                n_acc = 1'b0;
                            end
                        end
                        FUNC_ERASE: begin
                            if (r_cursor != '0) begin
                                w_cmd.op = CELL_DEL;
                                n_cursor = r_cursor - CW'(1);
                                n_length = r_length - CW'(1);
                            end else begin
                                n_acc = 1'b0;
                            end
                        end
                        FUNC_READ: begin
                            if (w_idx_ok) begin
                                // hold the result until the ring has come round
                                n_valid  = 1'b0;
                                n_rvalid = 1'b1;
                                n_state  = S_READ;
                                n_cnt    = '0;
                                n_idx    = i_index;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                w_cmd.op = CELL_ROT;
                n_cnt    = r_cnt + IW'(1);
                if (XW'(r_cnt) == XW'(r_idx)) begin
                    n_rchar = w_char[0];
                end
                if (r_cnt == IW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cursor  <= '0;
            r_length  <= '0;
            r_max_len <= MAX_LEN_RESET;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_length  <= n_length;
            r_max_len <= n_max_len;
            r_cnt     <= n_cnt;
            r_valid   <= n_valid;
        end
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_rchar  <= n_rchar;
        r_rvalid <= n_rvalid;
    end

    // ring of character cells; rotation walks it towards cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lebuf_cell #(
            .CELL_IDX (g),
            .CW       (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cmd    (w_cmd),
            .i_cursor (r_cursor),
            .i_left   (w_char[(g + CAPACITY - 1) % CAPACITY]),
            .i_right  (w_char[(g + 1) % CAPACITY]),
            .o_char   (w_char[g])
        );
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_accepted    = r_acc;
    assign o_read_char   = r_rchar;
    assign o_read_valid  = r_rvalid;
    assign o_cursor_pos  = 8'(r_cursor);
    assign o_text_length = 8'(r_length);

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_MAX_LENGTH) ? {24'd0, r_max_len} : 32'd0;

endmodule
`default_nettype wire

// ===== hdl/lebuf_checker.sv =====
// Port-level checks for the line edit buffer, bound to the top level.
`default_nettype none
module lebuf_checker
    import lebuf_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [2:0] i_func,
    input wire logic       o_valid,
    input wire logic       o_accepted,
    input wire logic [6:0] o_read_char,
    input wire logic       o_read_valid,
    input wire logic [7:0] o_cursor_pos,
    input wire logic [7:0] o_text_length
);

    // cursor never runs past the end of the text
    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_pos <= o_text_length))
        else $error("cursor beyond text length");

    // a refused or absent read shows no character
    a_read_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_read_valid) |-> (o_read_char == 7'd0))
        else $error("read character without valid read");

    // home answers in the next cycle with the cursor at the start
    a_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_HOME)) |=>
            (o_valid && o_accepted && (o_cursor_pos == 8'd0)))
        else $error("home did not return cursor to start");

    // an accepted erase shortens the text by one
    a_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_ERASE)) |=>
            (o_valid && (!o_accepted
                || (o_text_length + 8'd1 == $past(o_text_length)))))
        else $error("erase length step wrong");

endmodule

bind line_edit_buffer_core lebuf_checker u_lebuf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .o_accepted    (o_accepted),
    .o_read_char   (o_read_char),
    .o_read_valid  (o_read_valid),
    .o_cursor_pos  (o_cursor_pos),
    .o_text_length (o_text_length)
);
`default_nettype wire
